>>> sv/etqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking queue package
// Field widths, operation and status codes, register indexes and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package etqm_pkg;

  localparam int OP_W     = 3;
  localparam int PID_W    = 16;
  localparam int LEN_W    = 17;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int TOTAL_W  = 24;
  localparam int CAP_W    = 8;
  localparam int FRAC_W   = 11;
  localparam int FRAC_BITS = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_PULL   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 1'd1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 8'd100;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 11'd819;

  // Read address selection for the descriptor memory.
  localparam logic [1:0] RS_REQ = 2'd0;  // head, or the peek position
  localparam logic [1:0] RS_K1  = 2'd1;  // position k + 1
  localparam logic [1:0] RS_K2  = 2'd2;  // position k + 2

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       k_inc;
    logic       hold_load;
    logic       shift_wr;
    logic       finish;
  } etqm_cmd_t;

  typedef struct packed {
    logic start_search;
    logic match;
    logic last;
    logic last2;
    logic out_free;
  } etqm_sts_t;

endpackage

>>> sv/etqm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking queue request channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface etqm_req_if;
  import etqm_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [PID_W-1:0] packet_id;
  logic [LEN_W-1:0] packet_length;
  logic [POS_W-1:0] queue_position;

  modport source (
    output valid, operation, packet_id, packet_length, queue_position,
    input  ready
  );

  modport sink (
    input  valid, operation, packet_id, packet_length, queue_position,
    output ready
  );
endinterface

>>> sv/etqm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking queue response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface etqm_rsp_if;
  import etqm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PID_W-1:0]    out_packet_id;
  logic [LEN_W-1:0]    out_packet_length;
  logic                ecn_ce;
  logic [COUNT_W-1:0]  queue_count;
  logic [TOTAL_W-1:0]  total_bits;

  modport source (
    output valid, status, out_packet_id, out_packet_length, ecn_ce,
           queue_count, total_bits,
    input  ready
  );

  modport sink (
    input  valid, status, out_packet_id, out_packet_length, ecn_ce,
           queue_count, total_bits,
    output ready
  );
endinterface

>>> sv/etqm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module etqm_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/etqm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking queue controller
// Sequences accept, the identifier search, the compaction sweep and the
// result hand-off.
// ----------------------------------------------------------------------------
module etqm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  etqm_pkg::etqm_sts_t sts,
  output etqm_pkg::etqm_cmd_t cmd
);
  import etqm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RS_REQ;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          cmd.rd_en  = 1'b1;
          state_next = sts.start_search ? S_SRCH : S_FIN;
        end
      end
      S_SRCH: begin
        // The word read last cycle is the entry at position k.
        if (sts.match) begin
          cmd.hold_load = 1'b1;
          if (!sts.last) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_K1;
            state_next = S_SHIFT;
          end else begin
            state_next = S_FIN;
          end
        end else if (!sts.last) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_K1;
          cmd.k_inc  = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHIFT: begin
        // The entry at k + 1 is in the read register and moves down to k.
        cmd.shift_wr = 1'b1;
        cmd.k_inc    = 1'b1;
        if (!sts.last2) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_K2;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while the output word is still held");

  a_shift_after_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> ($past(state) == S_SHIFT || $past(sts.match)))
    else $error("compaction started without a matching entry");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.accept)
    else $error("word accepted while an operation is in progress");
`endif

endmodule

>>> sv/etqm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking queue datapath
// Descriptor memory, head, occupancy and bit total, marking compare,
// search index and the result register.
// ----------------------------------------------------------------------------
module etqm_dpath #(
  parameter int DEPTH   = 128,
  parameter int ID_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [etqm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [etqm_pkg::CFG_DATA_W-1:0]   cfg_data,
  etqm_req_if.sink                          request,
  etqm_rsp_if.source                        response,
  input  etqm_pkg::etqm_cmd_t               cmd,
  output etqm_pkg::etqm_sts_t               sts
);
  import etqm_pkg::*;

  localparam int ID_W    = (ID_BITS < PID_W) ? ID_BITS : PID_W;
  localparam int ENTRY_W = ID_W + LEN_W + 1;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = OCC_W + 1;
  localparam int CMP_W   = (OCC_W > POS_W) ? OCC_W : POS_W;
  localparam int PROD_W  = CAP_W + FRAC_W;
  localparam int MARK_W  = ((OCC_W + FRAC_BITS) > PROD_W) ? (OCC_W + FRAC_BITS) : PROD_W;

  // Queue state and configuration.
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  occ_next;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [CAP_W-1:0]  cap;
  logic [FRAC_W-1:0] frac;

  // Latched operation word.
  logic [OP_W-1:0]  op_reg;
  logic [ID_W-1:0]  id_reg;
  logic [LEN_W-1:0] len_reg;
  logic [POS_W-1:0] pos_reg;

  // Search index and the removed descriptor.
  logic [OCC_W-1:0] k;
  logic             found;
  logic [ID_W-1:0]  hold_id;
  logic [LEN_W-1:0] hold_len;
  logic             hold_ce;

  // Memory ports.
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [PTR_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ID_W-1:0]    rd_id;
  logic [LEN_W-1:0]   rd_len;
  logic               rd_ce;

  // Result values.
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [LEN_W-1:0]    res_len;
  logic                res_ce;

  logic              full;
  logic              mark;
  logic [PROD_W-1:0] level;
  logic [SUM_W-1:0]  k1_w;
  logic [SUM_W-1:0]  k2_w;
  logic              push_wr;

  // Physical slot of a position counted from the head.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] hd,
                                            input logic [OCC_W-1:0] x);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(hd) + SUM_W'(x);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return PTR_W'(sum);
  endfunction

  assign rd_id  = rd_data[ID_W-1:0];
  assign rd_len = rd_data[ID_W +: LEN_W];
  assign rd_ce  = rd_data[ENTRY_W-1];

  assign full  = (occ == OCC_W'(DEPTH));
  assign level = PROD_W'(cap) * PROD_W'(frac);
  assign mark  = ((MARK_W'(occ) << FRAC_BITS) >= MARK_W'(level));

  assign k1_w = SUM_W'(k) + SUM_W'(1);
  assign k2_w = SUM_W'(k) + SUM_W'(2);

  assign sts.start_search = (request.operation == OP_REMOVE) && (occ != '0);
  assign sts.match        = (rd_id == id_reg);
  assign sts.last         = (k1_w >= SUM_W'(occ));
  assign sts.last2        = (k2_w >= SUM_W'(occ));
  assign sts.out_free     = !response.valid || response.ready;

  always_comb begin
    case (cmd.rd_sel)
      RS_K1:   rd_addr = slot(head, OCC_W'(k1_w));
      RS_K2:   rd_addr = slot(head, OCC_W'(k2_w));
      default: begin
        if (request.operation == OP_PEEK) begin
          rd_addr = slot(head, OCC_W'(request.queue_position));
        end else begin
          rd_addr = head;
        end
      end
    endcase
  end

  assign push_wr = cmd.finish && (op_reg == OP_PUSH) && !full;
  assign wr_en   = cmd.shift_wr || push_wr;
  assign wr_addr = cmd.shift_wr ? slot(head, k) : slot(head, occ);
  assign wr_data = cmd.shift_wr ? rd_data : {mark, len_reg, id_reg};

  etqm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result and state update of the operation in its final cycle.
  always_comb begin
    res_status = ST_OK;
    res_id     = '0;
    res_len    = '0;
    res_ce     = 1'b0;
    head_next  = head;
    occ_next   = occ;
    total_next = total;
    case (op_reg)
      OP_PUSH: begin
        res_id  = id_reg;
        res_len = len_reg;
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_ce     = mark;
          occ_next   = occ + OCC_W'(1);
          total_next = total + TOTAL_W'(len_reg);
        end
      end
      OP_PULL: begin
        if (occ == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_id     = rd_id;
          res_len    = rd_len;
          res_ce     = rd_ce;
          head_next  = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
          occ_next   = occ - OCC_W'(1);
          total_next = total - TOTAL_W'(rd_len);
        end
      end
      OP_REMOVE: begin
        if (occ == '0) begin
          res_status = ST_EMPTY;
        end else if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_id     = hold_id;
          res_len    = hold_len;
          res_ce     = hold_ce;
          occ_next   = occ - OCC_W'(1);
          total_next = total - TOTAL_W'(hold_len);
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        occ_next   = '0;
        total_next = '0;
      end
      OP_PEEK: begin
        if (CMP_W'(pos_reg) >= CMP_W'(occ)) begin
          res_status = ST_BAD_POS;
        end else begin
          res_id  = rd_id;
          res_len = rd_len;
          res_ce  = rd_ce;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      occ            <= '0;
      total          <= '0;
      cap            <= CAP_RESET;
      frac           <= FRAC_RESET;
      found          <= 1'b0;
      response.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CAPACITY: cap  <= cfg_data[CAP_W-1:0];
          REG_FRACTION: frac <= cfg_data;
          default:      cap  <= cap;
        endcase
      end
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (cmd.hold_load) begin
        found <= 1'b1;
      end
      if (cmd.finish) begin
        head           <= head_next;
        occ            <= occ_next;
        total          <= total_next;
        response.valid <= 1'b1;
      end else if (response.ready) begin
        response.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_reg  <= request.operation;
      id_reg  <= ID_W'(request.packet_id);
      len_reg <= request.packet_length;
      pos_reg <= request.queue_position;
      k       <= '0;
    end else if (cmd.k_inc) begin
      k <= k + OCC_W'(1);
    end
    if (cmd.hold_load) begin
      hold_id  <= rd_id;
      hold_len <= rd_len;
      hold_ce  <= rd_ce;
    end
    if (cmd.finish) begin
      response.status            <= res_status;
      response.out_packet_id     <= PID_W'(res_id);
      response.out_packet_length <= res_len;
      response.ecn_ce            <= res_ce;
      response.queue_count       <= COUNT_W'(occ_next);
      response.total_bits        <= total_next;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    (occ <= OCC_W'(DEPTH)) && (head <= PTR_W'(DEPTH - 1)))
    else $error("occupancy or head pointer out of range");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> response.valid)
    else $error("finished operation produced no result word");

  a_shift_found: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> found && (op_reg == OP_REMOVE))
    else $error("compaction write without a removed entry");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(occ) && $stable(total))
    else $error("queue state changed outside the final cycle");
`endif

endmodule

>>> sv/ecn_threshold_marking_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN threshold marking queue
// Packet descriptor FIFO that marks congestion-experienced on push once the
// occupancy reaches capacity times the mark fraction, with pull, remove by
// identifier, clear and peek.
//
//   Channel    Dir  Handshake          Word
//   request    in   valid / ready      operation, packet_id, packet_length,
//                                      queue_position
//   response   out  valid / ready      status, out_packet_id,
//                                      out_packet_length, ecn_ce,
//                                      queue_count, total_bits
//   cfg        in   cfg_write          cfg_index, cfg_data
//
// Push, pull, peek, clear: the word is accepted and the descriptor memory
// read, then state is updated and the result register loaded. Remove: the
// search reads from the head to the match and the compaction moves each
// later entry down one position; a miss searches the whole queue and an
// empty queue none. Both take one memory access a cycle through the single ports.
// Reset is synchronous; the descriptor memory needs no clearing pass.
// A waiting result does not block accepting the next word; that word's result
// waits until the output register is taken.
// ----------------------------------------------------------------------------
module ecn_threshold_marking_queue #(
  parameter int DEPTH   = 128,
  parameter int ID_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [etqm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etqm_pkg::CFG_DATA_W-1:0] cfg_data,
  etqm_req_if.sink                        request,
  etqm_rsp_if.source                      response
);
  import etqm_pkg::*;

  etqm_cmd_t cmd;
  etqm_sts_t sts;
  logic      ready;

  assign request.ready = ready;

  etqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  etqm_dpath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .response  (response),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
